>>> design/lkvc_pkg.sv
package lkvc_pkg;

	// Widths fixed by the item fields and the register map.
	localparam int DATA_W = 32;
	localparam int CAP_W = 5;
	localparam int PADDR_W = 3;

	// Default geometry of the store.
	localparam int ENTRIES_DEF = 16;
	localparam int KEY_BITS_DEF = 32;

	// Capacity register reset value and register index.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam logic REG_CAPACITY = 1'b0;

	// Value returned by a get that misses.
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} opcode_t;

	// One result beat.
	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [DATA_W-1:0] evicted_key;
	} result_t;

endpackage

>>> design/lkvc_store.sv
module lkvc_store
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  opcode_t           opcode,
	input  logic [DATA_W-1:0] key,
	input  logic [DATA_W-1:0] value,
	input  logic [CAP_W-1:0]  capacity,
	output result_t           result
);

	localparam int KEY_W = (KEY_BITS < DATA_W) ? KEY_BITS : DATA_W;
	localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   key_q   [ENTRIES];
	logic [DATA_W-1:0]  value_q [ENTRIES];
	logic [RANK_W-1:0]  rank_q  [ENTRIES];
	logic [OCC_W-1:0]   occ_q;

	logic [KEY_W-1:0]   key_m;
	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] victim;
	logic [ENTRIES-1:0] victim_oh;
	logic [ENTRIES-1:0] kept;
	logic [ENTRIES-1:0] free_oh;
	logic [ENTRIES-1:0] valid_d;
	logic [RANK_W-1:0]  rank_d  [ENTRIES];
	logic [OCC_W-1:0]   occ_d;
	logic [OCC_W-1:0]   occ_m1;
	logic [RANK_W-1:0]  last_rank;
	logic [DATA_W-1:0]  hit_value;
	logic [RANK_W-1:0]  hit_rank;
	logic [KEY_W-1:0]   evict_key;
	logic [CMP_W-1:0]   cap_ext;
	logic [CMP_W-1:0]   eff_cap;
	logic               hit;
	logic               full;
	logic               do_evict;
	logic               insert;

	// Effective capacity: zero counts as one, large values saturate.
	always_comb begin
		cap_ext = CMP_W'(capacity);
		if (capacity == '0) begin
			eff_cap = CMP_W'(1);
		end else if (cap_ext > CMP_W'(ENTRIES)) begin
			eff_cap = CMP_W'(ENTRIES);
		end else begin
			eff_cap = cap_ext;
		end
		full = CMP_W'(occ_q) >= eff_cap;
	end

	// Parallel key compare and selection of the hit line and the victim.
	// Ranks of valid lines form a permutation, so the victim is the line
	// holding the highest rank in use.
	always_comb begin
		key_m = key[KEY_W-1:0];
		occ_m1 = occ_q - OCC_W'(1);
		last_rank = occ_m1[RANK_W-1:0];
		hit_value = '0;
		hit_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (key_q[i] == key_m);
			victim[i] = valid_q[i] && (rank_q[i] == last_rank);
			hit_value = hit_value | (value_q[i] & {DATA_W{match[i]}});
			hit_rank = hit_rank | (rank_q[i] & {RANK_W{match[i]}});
		end
		hit = |match;
		insert = (opcode == OP_PUT) && !hit;
		do_evict = insert && full;
		victim_oh = do_evict ? victim : '0;
		evict_key = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			evict_key = evict_key | (key_q[i] & {KEY_W{victim_oh[i]}});
		end
		kept = valid_q & ~victim_oh;
		// Lowest free line after the eviction.
		free_oh = ~kept & (kept + ENTRIES'(1));
	end

	// Result of the operation.
	always_comb begin
		result.hit = hit;
		if (opcode == OP_GET) begin
			result.read_value = hit ? hit_value : MISS_VALUE;
		end else begin
			result.read_value = '0;
		end
		result.evicted = do_evict;
		result.evicted_key = DATA_W'(evict_key);
	end

	// Next valid marks, ranks and occupancy.
	always_comb begin
		valid_d = valid_q;
		occ_d = occ_q;
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (hit) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (match[i]) begin
					rank_d[i] = '0;
				end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
		end else if (insert) begin
			valid_d = kept | free_oh;
			occ_d = occ_q - OCC_W'(do_evict) + OCC_W'(1);
			for (int i = 0; i < ENTRIES; i++) begin
				if (free_oh[i]) begin
					rank_d[i] = '0;
				end else if (kept[i]) begin
					rank_d[i] = rank_q[i] + RANK_W'(1);
				end
			end
		end
	end

	// Control state: valid marks and occupancy are cleared at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q <= '0;
		end else if (fire) begin
			valid_q <= valid_d;
			occ_q <= occ_d;
		end
	end

	// Line contents carry no reset.
	always_ff @(posedge clk) begin
		if (fire) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
				if (insert && free_oh[i]) begin
					key_q[i] <= key_m;
					value_q[i] <= value;
				end else if (hit && (opcode == OP_PUT) && match[i]) begin
					value_q[i] <= value;
				end
			end
		end
	end

endmodule

>>> design/lru_key_value_cache_unit.sv
// Channel   Handshake            Beat contents
// request   req_valid/req_ready  opcode, key, value
// response  rsp_valid/rsp_ready  hit, read_value, evicted, evicted_key
// config    APB write/read       capacity at byte address 0
//
// One item is taken every cycle while the response side does not stall; it passes
// through the input register and its result is offered from the result register.
// The whole lookup, eviction and rank update runs in the cycle the item leaves
// the input register, so the next item already sees the updated store.
// Reset empties the store and sets capacity to 16.
// A stall on the response side holds the result register, then the input
// register, and req_ready drops only when both are held.
module lru_key_value_cache_unit
	import lkvc_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic               opcode,
	input  logic [DATA_W-1:0]  key,
	input  logic [DATA_W-1:0]  value,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic               hit,
	output logic [DATA_W-1:0]  read_value,
	output logic               evicted,
	output logic [DATA_W-1:0]  evicted_key
);

	logic [CAP_W-1:0]  capacity_q;
	logic              valid_s1;
	opcode_t           opcode_s1;
	logic [DATA_W-1:0] key_s1;
	logic [DATA_W-1:0] value_s1;
	logic              valid_s2;
	result_t           result_s2;
	result_t           result;
	logic              fire;
	logic              cap_write;

	// Configuration port: single capacity register.
	assign pready = 1'b1;
	assign cap_write = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);
	assign prdata = (paddr[2] == REG_CAPACITY) ? DATA_W'(capacity_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cap_write) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	// The input register advances when the result register is empty or being drained.
	assign fire = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			opcode_s1 <= opcode_t'(opcode);
			key_s1 <= key;
			value_s1 <= value;
		end
	end

	lkvc_store #(
		.ENTRIES (ENTRIES),
		.KEY_BITS(KEY_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.opcode  (opcode_s1),
		.key     (key_s1),
		.value   (value_s1),
		.capacity(capacity_q),
		.result  (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire) begin
			valid_s2 <= 1'b1;
		end else if (rsp_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign hit = result_s2.hit;
	assign read_value = result_s2.read_value;
	assign evicted = result_s2.evicted;
	assign evicted_key = result_s2.evicted_key;

	// A beat entering a full input register must see that register drain.
	a_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && valid_s1) |-> fire)
		else $error("request beat taken over a held input register");

	// A hit never evicts.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.hit && result_s2.evicted))
		else $error("eviction reported on a hit");

	// The evicted key reads zero unless a line was evicted.
	a_evict_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_s2.evicted) |-> (result_s2.evicted_key == '0))
		else $error("evicted key set without eviction");

	// A stalled result stays in the result register.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !rsp_ready) |=> (valid_s2 && $stable(result_s2)))
		else $error("stalled result changed");

endmodule

>>> test/lru_key_value_cache_unit_tb.sv
`timescale 1ns / 1ps

module lru_key_value_cache_unit_tb;
	import lkvc_pkg::*;

	localparam int LINES = ENTRIES_DEF;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 232;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic               opcode = OP_GET;
	logic [DATA_W-1:0]  key = '0;
	logic [DATA_W-1:0]  value = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b1;
	logic               hit;
	logic [DATA_W-1:0]  read_value;
	logic               evicted;
	logic [DATA_W-1:0]  evicted_key;

	// Shadow copy of the store, updated as each request beat is accepted.
	logic              line_used [LINES];
	logic [DATA_W-1:0] line_tag [LINES];
	logic [DATA_W-1:0] line_data [LINES];
	int                line_age [LINES];
	int                lines_held;
	logic [CAP_W-1:0]  capacity_reg;

	result_t pending_results [$];
	int      err_count = 0;
	int      sent_count = 0;
	int      hit_count = 0;
	int      evict_count = 0;
	int      setting_count = 0;
	bit      idle_gaps = 1'b1;
	bit      ready_stalls = 1'b1;
	int      hold_left = 0;

	lru_key_value_cache_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.opcode      (opcode),
		.key         (key),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Mostly short pauses, now and then a long one.
	function automatic int gap_length();
		if ($urandom_range(0, 99) < 80)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Move a line to the front; lines that were more recent slide back by one.
	function automatic void make_most_recent(int idx);
		int r;
		r = line_age[idx];
		for (int i = 0; i < LINES; i++)
			if (line_used[i] && line_age[i] < r)
				line_age[i]++;
		line_age[idx] = 0;
	endfunction

	// Apply one operation to the shadow store and return the result it must produce.
	function automatic result_t lru_lookup(opcode_t op, logic [DATA_W-1:0] k,
					       logic [DATA_W-1:0] v);
		result_t res;
		int      found;
		int      victim;
		int      limit;
		bit      placed;
		res = '0;
		found = -1;
		for (int i = 0; i < LINES; i++)
			if (found < 0 && line_used[i] && line_tag[i] == k)
				found = i;

		if (op == OP_GET) begin
			if (found >= 0) begin
				res.hit = 1'b1;
				res.read_value = line_data[found];
				make_most_recent(found);
				hit_count++;
			end else begin
				res.read_value = MISS_VALUE;
			end
			return res;
		end

		// A put of a present key overwrites the value and makes the line most recent.
		if (found >= 0) begin
			res.hit = 1'b1;
			line_data[found] = v;
			make_most_recent(found);
			hit_count++;
			return res;
		end

		// Zero counts as one line; anything above the store size saturates.
		if (capacity_reg == 0)
			limit = 1;
		else if (int'(capacity_reg) > LINES)
			limit = LINES;
		else
			limit = int'(capacity_reg);

		if (lines_held >= limit && lines_held > 0) begin
			victim = -1;
			for (int i = 0; i < LINES; i++)
				if (line_used[i] && (victim < 0 || line_age[i] >= line_age[victim]))
					victim = i;
			res.evicted = 1'b1;
			res.evicted_key = line_tag[victim];
			line_used[victim] = 1'b0;
			lines_held--;
			evict_count++;
		end

		// The new line goes into the lowest free slot as the most recent.
		placed = 1'b0;
		for (int i = 0; i < LINES; i++) begin
			if (!placed && !line_used[i]) begin
				for (int j = 0; j < LINES; j++)
					if (line_used[j])
						line_age[j]++;
				line_used[i] = 1'b1;
				line_tag[i] = k;
				line_data[i] = v;
				line_age[i] = 0;
				lines_held++;
				placed = 1'b1;
			end
		end
		return res;
	endfunction

	// Send one request beat; valid stays high afterward unless a gap follows.
	task automatic send_request(opcode_t op, logic [DATA_W-1:0] k, logic [DATA_W-1:0] v);
		int gap;
		gap = (idle_gaps && $urandom_range(0, 3) == 0) ? gap_length() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (!req_ready);
		pending_results.push_back(lru_lookup(op, k, v));
		sent_count++;
	endtask

	// Stop sending and let every outstanding result beat come back.
	task automatic wait_for_results();
		req_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write the capacity register with junk in the unused upper bits.
	task automatic set_capacity(logic [CAP_W-1:0] c);
		logic [DATA_W-1:0] word;
		wait_for_results();
		word = $urandom();
		word[CAP_W-1:0] = c;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(4 * int'(REG_CAPACITY));
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		capacity_reg = c;
		setting_count++;
	endtask

	// Lookups on the empty store at reset capacity must all miss.
	task automatic test_empty_store();
		send_request(OP_GET, 32'h0000_0000, $urandom());
		send_request(OP_GET, 32'h8000_0000, $urandom());
		send_request(OP_GET, 32'h7FFF_FFFF, $urandom());
		send_request(OP_GET, 32'hFFFF_FFFF, $urandom());
	endtask

	// Fill, hit, overwrite and evict with extreme keys and values.
	task automatic test_basic_ops();
		set_capacity(5'd3);
		send_request(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
		send_request(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_request(OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_request(OP_GET, 32'h8000_0000, $urandom());
		send_request(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(OP_GET, 32'h7FFF_FFFF, $urandom());
		send_request(OP_PUT, 32'h0000_0000, 32'h0000_0005);
		send_request(OP_GET, 32'h0000_0000, $urandom());
		send_request(OP_GET, 32'hFFFF_FFFF, $urandom());
	endtask

	// Capacity zero with the store over it, then a value above the store size.
	task automatic test_capacity_limits();
		set_capacity(5'd0);
		send_request(OP_PUT, 32'h1234_5678, 32'hA5A5_A5A5);
		send_request(OP_PUT, 32'hEDCB_A987, 32'h5A5A_5A5A);
		send_request(OP_GET, 32'h1234_5678, $urandom());
		send_request(OP_GET, 32'hEDCB_A987, $urandom());
		set_capacity(5'd31);
		send_request(OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
		send_request(OP_GET, 32'h0F0F_0F0F, $urandom());
	endtask

	// Phases of random traffic over a small key pool so that hits and evictions are common.
	task automatic test_random_traffic();
		logic [CAP_W-1:0]  phase_caps [RANDOM_PHASES];
		logic [DATA_W-1:0] corner_keys [4];
		logic [DATA_W-1:0] key_pool [24];
		logic [DATA_W-1:0] k;
		int                pool_size;
		opcode_t           op;
		phase_caps = '{5'd1, 5'd2, 5'd16, 5'd31, 5'd0, 5'd8, 5'd5, 5'd12};
		phase_caps[6] = CAP_W'($urandom_range(1, 16));
		phase_caps[7] = CAP_W'($urandom_range(0, 31));
		corner_keys = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			idle_gaps = (p % 3 != 1);
			ready_stalls = (p % 3 != 2);
			set_capacity(phase_caps[p]);
			pool_size = $urandom_range(2, 24);
			foreach (key_pool[i])
				key_pool[i] = $urandom();
			key_pool[0] = corner_keys[p % 4];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// Hold off once per phase, and now and then, until the pipe is empty.
				if (n == PHASE_ITEMS / 2 || $urandom_range(0, 199) == 0)
					wait_for_results();
				op = opcode_t'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_size - 1)];
				else
					k = $urandom();
				send_request(op, k, $urandom());
			end
		end
	endtask

	// Response side: bursts of stalls, or ready held high.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= (hold_left == 1);
		end else if (ready_stalls && $urandom_range(0, 5) == 0) begin
			rsp_ready <= 1'b0;
			hold_left <= gap_length();
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest prediction.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing pending: hit=%0b read_value=%h",
				       hit, read_value);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (hit !== want.hit) begin
					$error("hit: expected %0b, got %0b", want.hit, hit);
					err_count++;
				end
				if (read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, read_value);
					err_count++;
				end
				if (evicted !== want.evicted) begin
					$error("evicted: expected %0b, got %0b", want.evicted, evicted);
					err_count++;
				end
				if (evicted_key !== want.evicted_key) begin
					$error("evicted_key: expected %h, got %h",
					       want.evicted_key, evicted_key);
					err_count++;
				end
			end
		end
	end

	initial begin
		foreach (line_used[i]) begin
			line_used[i] = 1'b0;
			line_tag[i] = '0;
			line_data[i] = '0;
			line_age[i] = 0;
		end
		lines_held = 0;
		capacity_reg = CAP_RESET;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_store();
		test_basic_ops();
		test_capacity_limits();
		test_random_traffic();

		wait_for_results();
		repeat (10) @(posedge clk);
		$display("Sent %0d requests under %0d capacity settings.", sent_count, setting_count);
		$display("Saw %0d hits and %0d evictions among them.", hit_count, evict_count);
		if (err_count == 0)
			$display("lru_key_value_cache_unit_tb: clean");
		else
			$display("lru_key_value_cache_unit_tb: errors");
		$finish;
	end

	// Watchdog far beyond the slowest legal run.
	initial begin
		#4_000_000;
		$display("lru_key_value_cache_unit_tb: errors");
		$finish;
	end

endmodule
